[sv/base64_stream_codec_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream codec
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_TOP_MACROS_SVH
`define BASE64_STREAM_CODEC_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64SC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("b64sc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define B64SC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("b64sc: next-cycle check failed");

`endif

[sv/b64sc_pkg.sv]
// ----------------------------------------------------------------------------
// b64sc_pkg
// Types, constants and alphabet functions shared by the base64 codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Padding character.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Group job queue geometry.
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    // One input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // One result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out;

    // One completed group, handed from the front to the back.
    // n_real: real characters (encode, 2..4) or bytes (decode, 0..3, 0 for a marker).
    typedef struct packed {
        logic [23:0] value;
        logic [2:0]  n_real;
        logic        encode;
        logic        last;
        logic        marker;
    } t_job;

    // Map a sextet to its alphabet character.
    function automatic logic [7:0] char_of(input logic [5:0] s);
        logic [7:0] s8;
        s8 = {2'b00, s};
        if (s < 6'd26) begin
            return 8'h41 + s8;
        end else if (s < 6'd52) begin
            return 8'h61 + (s8 - 8'd26);
        end else if (s < 6'd62) begin
            return 8'h30 + (s8 - 8'd52);
        end else if (s == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Map a character to its sextet; characters outside the alphabet give zero.
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            d = 8'd62;
        end else if (c == 8'h2F) begin
            d = 8'd63;
        end
        return d[5:0];
    endfunction

endpackage

[sv/b64sc_front.sv]
// ----------------------------------------------------------------------------
// b64sc_front
// Gathers items into groups; issues a job per group with results or a last item.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_top_macros.svh"

module b64sc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  b64sc_pkg::t_in    i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_dir,
    output logic              o_job_push,
    output b64sc_pkg::t_job   o_job
);

    logic        r_dir, n_dir;
    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_pads, n_pads;

    logic [1:0]  held_e;
    logic        is_pad;
    logic [5:0]  sext;
    logic [1:0]  pads_d;
    logic [2:0]  positions;
    logic [2:0]  real_cnt;
    logic [2:0]  nbytes;
    logic [23:0] enc_raw;
    logic [23:0] dec_raw;
    logic [23:0] enc_val;
    logic [23:0] dec_val;

    // Classification of the incoming item.
    always_comb begin
        held_e    = (r_cnt > 2'd2) ? 2'd2 : r_cnt;
        is_pad    = (i_item.in_byte == b64sc_pkg::PAD_CHAR);
        sext      = is_pad ? 6'd0 : b64sc_pkg::sextet_of(i_item.in_byte);
        pads_d    = (is_pad && r_pads < 2'd3) ? r_pads + 2'd1 : r_pads;
        positions = {1'b0, r_cnt} + 3'd1;
        real_cnt  = (positions > {1'b0, pads_d}) ? positions - {1'b0, pads_d} : 3'd0;
        nbytes    = (real_cnt > 3'd1) ? real_cnt - 3'd1 : 3'd0;
        enc_raw   = {r_buf[15:0], i_item.in_byte};
        dec_raw   = {r_buf, sext};
    end

    // Align the held bytes at the top of the 24-bit group.
    always_comb begin
        unique case (held_e)
            2'd0:    enc_val = enc_raw << 16;
            2'd1:    enc_val = enc_raw << 8;
            default: enc_val = enc_raw;
        endcase
    end

    // Align the held sextets at the top of the 24-bit group.
    always_comb begin
        unique case (r_cnt)
            2'd0:    dec_val = dec_raw << 18;
            2'd1:    dec_val = dec_raw << 12;
            2'd2:    dec_val = dec_raw << 6;
            default: dec_val = dec_raw;
        endcase
    end

    // Group state update and job issue.
    always_comb begin
        n_dir      = r_dir;
        n_buf      = r_buf;
        n_cnt      = r_cnt;
        n_pads     = r_pads;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_cfg_we) begin
            n_dir  = i_cfg_dir;
            n_buf  = '0;
            n_cnt  = '0;
            n_pads = '0;
        end else if (i_acc) begin
            if (r_dir == b64sc_pkg::DIR_ENCODE) begin
                if (held_e < 2'd2 && !i_item.in_last) begin
                    n_buf = {2'b00, r_buf[7:0], i_item.in_byte};
                    n_cnt = held_e + 2'd1;
                end else begin
                    o_job_push   = 1'b1;
                    o_job.value  = enc_val;
                    o_job.n_real = {1'b0, held_e} + 3'd2;
                    o_job.encode = 1'b1;
                    o_job.last   = i_item.in_last;
                    n_buf  = '0;
                    n_cnt  = '0;
                    n_pads = '0;
                end
            end else begin
                if (r_cnt < 2'd3 && !i_item.in_last) begin
                    n_buf  = {r_buf[11:0], sext};
                    n_cnt  = r_cnt + 2'd1;
                    n_pads = pads_d;
                end else begin
                    o_job_push   = (nbytes != 3'd0) || i_item.in_last;
                    o_job.value  = dec_val;
                    o_job.n_real = nbytes;
                    o_job.encode = 1'b0;
                    o_job.last   = i_item.in_last;
                    o_job.marker = (nbytes == 3'd0);
                    n_buf  = '0;
                    n_cnt  = '0;
                    n_pads = '0;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= b64sc_pkg::DIR_ENCODE;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_pads <= '0;
        end else begin
            r_dir  <= n_dir;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_pads <= n_pads;
        end
    end

    // A last item always closes its group.
    `B64SC_ASSERT_NEXT(a_last_clears, i_acc && i_item.in_last, r_cnt == 2'd0 && r_pads == 2'd0)

endmodule

[sv/b64sc_jobq.sv]
// ----------------------------------------------------------------------------
// b64sc_jobq
// Short register queue of group jobs between the front and the back.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_top_macros.svh"

module b64sc_jobq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64sc_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output b64sc_pkg::t_job   o_head
);

    localparam logic [b64sc_pkg::JOBQ_AW-1:0] LAST_PTR =
        b64sc_pkg::JOBQ_AW'(b64sc_pkg::JOBQ_DEPTH - 1);
    localparam logic [b64sc_pkg::JOBQ_CW-1:0] DEPTH_CNT =
        b64sc_pkg::JOBQ_CW'(b64sc_pkg::JOBQ_DEPTH);
    localparam logic [b64sc_pkg::JOBQ_AW-1:0] PTR_ONE = b64sc_pkg::JOBQ_AW'(1);
    localparam logic [b64sc_pkg::JOBQ_CW-1:0] CNT_ONE = b64sc_pkg::JOBQ_CW'(1);

    b64sc_pkg::t_job r_mem [b64sc_pkg::JOBQ_DEPTH];
    logic [b64sc_pkg::JOBQ_AW-1:0] r_wptr, n_wptr;
    logic [b64sc_pkg::JOBQ_AW-1:0] r_rptr, n_rptr;
    logic [b64sc_pkg::JOBQ_CW-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_ONE;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_ONE;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_ONE;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_ONE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Occupancy stays within the queue depth.
    `B64SC_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= DEPTH_CNT)
    // A stored job makes the queue non-empty.
    `B64SC_ASSERT_NEXT(a_push_fills, do_push, r_cnt != '0)

endmodule

[sv/b64sc_back.sv]
// ----------------------------------------------------------------------------
// b64sc_back
// Expands each group job into characters, bytes or an end marker, one result per cycle,
// into an output register while it is empty or being popped.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_top_macros.svh"

module b64sc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  b64sc_pkg::t_job   i_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output b64sc_pkg::t_out   o_out
);

    logic [1:0]       r_idx, n_idx;
    logic             r_full, n_full;
    b64sc_pkg::t_out  r_res;
    b64sc_pkg::t_out  res;
    logic [2:0]       total;
    logic             at_end;
    logic             load;
    logic [5:0]       sext;
    logic [7:0]       dbyte;

    // Number of results the head job gives.
    always_comb begin
        if (i_head.marker) begin
            total = 3'd1;
        end else if (i_head.encode) begin
            total = 3'd4;
        end else begin
            total = i_head.n_real;
        end
    end

    assign at_end = ({1'b0, r_idx} + 3'd1) >= total;
    assign load   = !i_q_empty && (!r_full || i_pop);

    // Select the sextet and the byte at the current position.
    always_comb begin
        unique case (r_idx)
            2'd0: begin
                sext  = i_head.value[23:18];
                dbyte = i_head.value[23:16];
            end
            2'd1: begin
                sext  = i_head.value[17:12];
                dbyte = i_head.value[15:8];
            end
            2'd2: begin
                sext  = i_head.value[11:6];
                dbyte = i_head.value[7:0];
            end
            default: begin
                sext  = i_head.value[5:0];
                dbyte = 8'd0;
            end
        endcase
    end

    // Form the result at the current position.
    always_comb begin
        res = '0;
        if (i_head.marker) begin
            res.out_last = 1'b1;
        end else if (i_head.encode) begin
            res.out_byte  = ({1'b0, r_idx} < i_head.n_real) ?
                            b64sc_pkg::char_of(sext) : b64sc_pkg::PAD_CHAR;
            res.out_valid = 1'b1;
            res.out_last  = i_head.last && at_end;
        end else begin
            res.out_byte  = dbyte;
            res.out_valid = 1'b1;
            res.out_last  = i_head.last && at_end;
        end
    end

    // Position counter and output occupancy.
    always_comb begin
        n_idx   = r_idx;
        n_full  = r_full && !i_pop;
        o_q_pop = 1'b0;
        if (load) begin
            n_full = 1'b1;
            if (at_end) begin
                n_idx   = 2'd0;
                o_q_pop = 1'b1;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_full <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_full <= n_full;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= res;
        end
    end

    assign o_empty = !r_full;
    assign o_out   = r_res;

    // The position never runs past the job's result count.
    `B64SC_ASSERT_NOW(a_idx_bound, !i_q_empty, {1'b0, r_idx} < total)

endmodule

[sv/base64_stream_codec_top.sv]
// The first result of a group is stored in the job queue when the item closing the group
// is accepted, then in the output register; the rest follow one per cycle while popped.
// Throughput: one item per cycle in while the queue has room, one result per cycle out
// while popped; encoding a long stream gives four results per three items, bound by the
// result port. A four-entry group job queue lets input run ahead of a stalled result
// side. Reset (synchronous, active low) sets encode mode and clears all group state.
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Standard-alphabet base64 stream encoder and decoder.
// ----------------------------------------------------------------------------
module base64_stream_codec_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  b64sc_pkg::t_in    i_in,
    output logic              o_empty,
    input  logic              i_pop,
    output b64sc_pkg::t_out   o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_direction
);

    logic            acc;
    logic            cfg_we;
    logic            job_push;
    b64sc_pkg::t_job job;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    b64sc_pkg::t_job q_head;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_full      = q_full;
    assign acc         = i_push && !q_full;

    // Front: gathers items into groups.
    b64sc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_item     (i_in),
        .i_cfg_we   (cfg_we),
        .i_cfg_dir  (i_cfg_direction),
        .o_job_push (job_push),
        .o_job      (job)
    );

    // Queue of completed groups.
    b64sc_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: expands groups into results.
    b64sc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_out     (o_out)
    );

endmodule

[tb/sv/base64_codec_checker.sv]
// ----------------------------------------------------------------------------
// base64_codec_checker
// Watches the input, result and direction channels of the base64 stream
// codec. It predicts every result from the accepted input requests and
// compares each popped result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module base64_codec_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  b64sc_pkg::t_in    i_in,
    input  logic              i_empty,
    input  logic              i_pop,
    input  b64sc_pkg::t_out   i_out,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_direction,
    output int                o_fail_count,
    output int                o_awaited
);

    // The standard alphabet, first character in the top byte.
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Predictor state: direction and the partial group.
    logic        dir_mode   = b64sc_pkg::DIR_ENCODE;
    logic [17:0] grp_bits   = '0;
    int          grp_fill   = 0;
    int          pad_seen   = 0;

    // Results still to come from the block, oldest first.
    b64sc_pkg::t_out awaited_symbols[$];

    int fail_total    = 0;
    int awaited_total = 0;

    assign o_fail_count = fail_total;
    assign o_awaited    = awaited_total;

    // Character for one sextet.
    function automatic logic [7:0] char_for(input logic [5:0] s);
        return B64_ALPHABET[8*(63 - int'(s)) +: 8];
    endfunction

    // Sextet for one character; anything outside the alphabet maps to zero.
    function automatic logic [5:0] sextet_for(input logic [7:0] c);
        logic [5:0] s;
        int         k;
        s = '0;
        for (k = 0; k < 64; k++) begin
            if (B64_ALPHABET[8*(63 - k) +: 8] == c) begin
                s = 6'(k);
            end
        end
        return s;
    endfunction

    function automatic b64sc_pkg::t_out make_out(input logic [7:0] b, input logic v,
                                                 input logic l);
        b64sc_pkg::t_out r;
        r.out_byte  = b;
        r.out_valid = v;
        r.out_last  = l;
        return r;
    endfunction

    task automatic reset_group_state();
        grp_bits = '0;
        grp_fill = 0;
        pad_seen = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] codec mismatch: %s", $realtime, what);
        fail_total++;
    endtask

    // Encode: gather three bytes, give four characters; the last request
    // flushes a partial group padded to four.
    task automatic predict_encode(input b64sc_pkg::t_in item);
        int          held;
        int          n_chars;
        int          i;
        logic [23:0] triple;
        logic [7:0]  ch;
        held = (grp_fill > 2) ? 2 : grp_fill;
        if (held < 2 && !item.in_last) begin
            grp_bits = {2'b00, grp_bits[7:0], item.in_byte};
            grp_fill = held + 1;
            return;
        end
        triple  = {grp_bits[15:0], item.in_byte} << (8 * (2 - held));
        n_chars = held + 2;
        for (i = 0; i < 4; i++) begin
            ch = (i < n_chars) ? char_for(triple[18 - 6*i +: 6]) : b64sc_pkg::PAD_CHAR;
            awaited_symbols.push_back(make_out(ch, 1'b1, item.in_last && i == 3));
        end
        reset_group_state();
    endtask

    // Decode: gather four sextets, give up to three bytes; each pad drops one.
    task automatic predict_decode(input b64sc_pkg::t_in item);
        int          held;
        int          pads;
        int          positions;
        int          n_real;
        int          n_bytes;
        int          i;
        logic [5:0]  s;
        logic [23:0] word;
        held = grp_fill;
        pads = pad_seen;
        s    = '0;
        if (item.in_byte == b64sc_pkg::PAD_CHAR) begin
            if (pads < 3) begin
                pads++;
            end
        end else begin
            s = sextet_for(item.in_byte);
        end
        if (held < 3 && !item.in_last) begin
            grp_bits = {grp_bits[11:0], s};
            grp_fill = held + 1;
            pad_seen = pads;
            return;
        end
        positions = held + 1;
        word      = {grp_bits, s} << (6 * (3 - held));
        n_real    = (positions > pads) ? positions - pads : 0;
        n_bytes   = (n_real > 1) ? n_real - 1 : 0;
        reset_group_state();
        if (n_bytes == 0) begin
            // A stream that ends with nothing to give still ends with a marker.
            if (item.in_last) begin
                awaited_symbols.push_back(make_out(8'h00, 1'b0, 1'b1));
            end
            return;
        end
        for (i = 0; i < n_bytes; i++) begin
            awaited_symbols.push_back(make_out(word[16 - 8*i +: 8], 1'b1,
                                               item.in_last && i == n_bytes - 1));
        end
    endtask

    task automatic compare_codec_output(input b64sc_pkg::t_out got);
        b64sc_pkg::t_out want;
        if (awaited_symbols.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h valid %0b last %0b",
                                      got.out_byte, got.out_valid, got.out_last));
            return;
        end
        want = awaited_symbols.pop_front();
        if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
        end
        if (got.out_valid !== want.out_valid) begin
            report_mismatch($sformatf("out_valid %0b, expected %0b",
                                      got.out_valid, want.out_valid));
        end
        if (got.out_last !== want.out_last) begin
            report_mismatch($sformatf("out_last %0b, expected %0b",
                                      got.out_last, want.out_last));
        end
    endtask

    // Results are checked before new requests are predicted, so a stray
    // result can never match a prediction made at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dir_mode = b64sc_pkg::DIR_ENCODE;
            reset_group_state();
            awaited_symbols.delete();
        end else begin
            if (i_pop && !i_empty) begin
                compare_codec_output(i_out);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                dir_mode = i_cfg_direction;
                reset_group_state();
            end
            if (i_push && !i_full) begin
                if (dir_mode == b64sc_pkg::DIR_ENCODE) begin
                    predict_encode(i_in);
                end else begin
                    predict_decode(i_in);
                end
            end
        end
        awaited_total = awaited_symbols.size();
    end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the base64 stream codec with directed and random streams in both
// directions under several idle and stall patterns; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              push          = 1'b0;
    logic              full;
    b64sc_pkg::t_in    in_req        = '0;
    logic              empty;
    logic              pop           = 1'b0;
    b64sc_pkg::t_out   out_res;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic              cfg_direction = 1'b0;

    int fail_count;
    int awaited;

    // Idle and stall rates in percent, and the current direction.
    int   send_idle_pct = 0;
    int   pop_stall_pct = 0;
    logic cur_dir       = b64sc_pkg::DIR_ENCODE;
    int   items_sent    = 0;

    base64_stream_codec_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_in            (in_req),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_out           (out_res),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_direction (cfg_direction)
    );

    base64_codec_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in            (in_req),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out           (out_res),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_direction (cfg_direction),
        .o_fail_count    (fail_count),
        .o_awaited       (awaited)
    );

    // Clock with a period of 8.
    initial begin
        forever begin
            #4 clk = ~clk;
        end
    end

    // Hard limit on the run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // The result side pops at random according to the stall rate.
    always @(negedge clk) begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    function automatic logic [7:0] rand_b64_char();
        return b64sc_pkg::char_of(6'($urandom_range(0, 63)));
    endfunction

    // One input request; returns at the falling edge after it is accepted,
    // with push still high so back-to-back requests need no extra edge.
    task automatic send_item(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push   <= 1'b1;
        in_req <= {b, l};
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string txt, input logic mark_end);
        int k;
        for (k = 0; k < txt.len(); k++) begin
            send_item(txt[k], mark_end && k == txt.len() - 1);
        end
    endtask

    // Stop sending and let every awaited result arrive, then give the block
    // time to finish groups that produce nothing.
    task automatic stop_and_drain();
        push <= 1'b0;
        while (awaited != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_direction(input logic dir);
        stop_and_drain();
        cfg_valid     <= 1'b1;
        cfg_direction <= dir;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_dir = dir;
    endtask

    // A well-formed encoded text: whole groups, the final one maybe padded.
    task automatic send_decode_stream();
        int groups;
        int pads;
        int g;
        int k;
        groups = $urandom_range(0, 2);
        pads   = $urandom_range(0, 2);
        for (g = 0; g < groups; g++) begin
            for (k = 0; k < 4; k++) begin
                send_item(rand_b64_char(), 1'b0);
            end
        end
        for (k = 0; k < 4; k++) begin
            if (k < 4 - pads) begin
                send_item(rand_b64_char(), k == 3);
            end else begin
                send_item(b64sc_pkg::PAD_CHAR, k == 3);
            end
        end
    endtask

    // A broken text: alphabet, pads and stray bytes mixed, maybe unterminated.
    task automatic send_broken_text();
        int         len;
        int         k;
        logic       ends;
        logic [7:0] c;
        len  = $urandom_range(1, 7);
        ends = 1'($urandom_range(0, 1));
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    c = rand_b64_char();
                end
                2: begin
                    c = b64sc_pkg::PAD_CHAR;
                end
                default: begin
                    c = 8'($urandom_range(0, 255));
                end
            endcase
            send_item(c, ends && k == len - 1);
        end
    endtask

    task automatic send_encode_stream();
        int len;
        int k;
        len = $urandom_range(1, 9);
        for (k = 0; k < len; k++) begin
            send_item(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // Mostly well-formed streams, with broken ones and single stray requests.
    task automatic run_random_block(input int count);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 9);
            if (cur_dir == b64sc_pkg::DIR_ENCODE) begin
                if (pick < 8) begin
                    send_encode_stream();
                end else begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                if (pick < 6) begin
                    send_decode_stream();
                end else if (pick < 9) begin
                    send_broken_text();
                end else begin
                    send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int phase;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed encoding: a full group, then flushes of one, two and
        // three pending bytes.
        write_direction(b64sc_pkg::DIR_ENCODE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'hFE, 1'b1);
        send_item(8'h7F, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hAA, 1'b1);

        // Directed decoding: a full group, stray characters with a pad in
        // the middle, an all-pad final group that ends with a bare marker,
        // and a short final group.
        write_direction(b64sc_pkg::DIR_DECODE);
        send_text("TWFu", 1'b0);
        send_text("*~=A", 1'b0);
        send_text("====", 1'b1);
        send_text("QUI", 1'b1);

        // Random part: each idle pattern in both directions.
        for (phase = 0; phase < 8; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 63;
                    pop_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 63;
                end
                default: begin
                    send_idle_pct = 9;
                    pop_stall_pct = 9;
                end
            endcase
            write_direction((phase % 2 == 0) ? b64sc_pkg::DIR_ENCODE : b64sc_pkg::DIR_DECODE);
            run_random_block(48);
        end

        stop_and_drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
